>>> hdl/priority_target_selector_assert.svh
// Assertion macros shared by the selector RTL.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef PRIORITY_TARGET_SELECTOR_ASSERT_SVH
`define PRIORITY_TARGET_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pts_pkg.sv
`default_nettype none

package pts_pkg;

  // Default geometry of the counter store
  localparam int NUM_COLORS_DEF = 5;
  localparam int NUM_LABELS_DEF = 15;

  // Priority walk limits
  localparam int PRIORITY_SLOTS = 5;
  localparam int REG_SLOTS      = 5;
  localparam int SLOT_CAP       = (PRIORITY_SLOTS < REG_SLOTS) ? PRIORITY_SLOTS : REG_SLOTS;
  localparam int SLOT_W         = 3;
  localparam int LABEL_W        = 4;
  localparam int COLOR_W        = 3;
  localparam int CNT_W          = 8;
  localparam int MASK_W         = 10;
  localparam int SHOOT_LABELS   = 10;

  localparam logic [LABEL_W-1:0] EMPTY_SLOT = 4'hF;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 8'hFF;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_COLOR = 3'd0,
    REG_PRIO_LIST    = 3'd1,
    REG_PRIO_COUNT   = 3'd2,
    REG_APPEAR_THR   = 3'd3,
    REG_LOST_LIMIT   = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [COLOR_W-1:0]    RST_TARGET_COLOR = 3'd0;
  localparam logic [CFG_DATA_W-1:0] RST_PRIO_LIST    = 20'h43210;
  localparam logic [SLOT_W-1:0]     RST_PRIO_COUNT   = 3'd5;
  localparam logic [CNT_W-1:0]      RST_APPEAR_THR   = 8'd5;
  localparam logic [CNT_W-1:0]      RST_LOST_LIMIT   = 8'd10;

  // Frame sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_WALK
  } state_t;

endpackage

`default_nettype wire

>>> hdl/priority_target_selector.sv
// Priority target selector. Detections stream in on in_* one word per cycle while the block
// is idle; the word with in_tlast closes a frame and yields exactly one result word on out_*.
// Input then stalls until the result is loaded into the output register, which also waits
// while the previous result waits on out_tready. The appearance counters live in one memory
// with one read and one write port, and the frame-end update sweeps it one entry per cycle,
// after which the priority list is walked one slot per cycle. The counters need no clearing
// pass after reset: a flag marks the memory as unwritten until the first sweep, and reads
// before then count as zero. Configuration writes are accepted in every cycle but are meant
// to be issued only while the block is idle.

`default_nettype none

`include "priority_target_selector_assert.svh"

module priority_target_selector #(
  parameter int NUM_COLORS = pts_pkg::NUM_COLORS_DEF,
  parameter int NUM_LABELS = pts_pkg::NUM_LABELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // detection input
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [23:0]                        in_tdata,  // det_color, det_label, shootable_mask
  input  wire logic                               in_tuser,  // det_valid
  input  wire logic                               in_tlast,  // last_of_frame
  // result output
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [7:0]                              out_tdata, // target_label, tracker_reset
  output logic                                    out_tuser, // target_valid
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pts_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PAIRS = NUM_COLORS * NUM_LABELS;
  localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CW    = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
  localparam int LW    = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;

  localparam int LBW = pts_pkg::LABEL_W;
  localparam int CNW = pts_pkg::CNT_W;

  // Unpack input word
  logic [pts_pkg::COLOR_W-1:0] det_color;
  logic [LBW-1:0]              det_label;
  logic [pts_pkg::MASK_W-1:0]  det_mask;
  logic                        det_valid;
  logic                        in_fire;
  logic                        det_in_range;

  assign det_color = in_tdata[2:0];
  assign det_label = in_tdata[6:3];
  assign det_mask  = in_tdata[16:7];
  assign det_valid = in_tuser;
  assign in_fire   = in_tvalid && in_tready;
  assign det_in_range = det_valid && ({1'b0, det_color} < 4'(NUM_COLORS)) &&
                        (det_label < 4'(NUM_LABELS));

  // Configuration registers
  logic [pts_pkg::COLOR_W-1:0]    target_color_r;
  logic [pts_pkg::CFG_DATA_W-1:0] prio_list_r;
  logic [pts_pkg::SLOT_W-1:0]     prio_count_r;
  logic [CNW-1:0]                 appear_thr_r;
  logic [CNW-1:0]                 lost_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_color_r <= pts_pkg::RST_TARGET_COLOR;
      prio_list_r    <= pts_pkg::RST_PRIO_LIST;
      prio_count_r   <= pts_pkg::RST_PRIO_COUNT;
      appear_thr_r   <= pts_pkg::RST_APPEAR_THR;
      lost_limit_r   <= pts_pkg::RST_LOST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pts_pkg::REG_TARGET_COLOR: target_color_r <= cfg_data[2:0];
        pts_pkg::REG_PRIO_LIST:    prio_list_r    <= cfg_data;
        pts_pkg::REG_PRIO_COUNT:   prio_count_r   <= cfg_data[2:0];
        pts_pkg::REG_APPEAR_THR:   appear_thr_r   <= cfg_data[7:0];
        pts_pkg::REG_LOST_LIMIT:   lost_limit_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers
  pts_pkg::state_t state_r, state_nxt;

  logic [NUM_COLORS-1:0][NUM_LABELS-1:0] seen_r;
  logic [NUM_LABELS-1:0]                 elig_r;
  logic [pts_pkg::MASK_W-1:0]            mask_r;
  logic                                  cnt_ok_r;

  logic [CW-1:0]  sw_col_r;
  logic [LW-1:0]  sw_lab_r;
  logic [AW-1:0]  sw_addr_r;
  logic           sw_last;

  logic           wb_vld_r;
  logic [CW-1:0]  wb_col_r;
  logic [LW-1:0]  wb_lab_r;
  logic [AW-1:0]  wb_addr_r;
  logic           wb_seen_r;
  logic [CNW-1:0] rd_data_r;
  logic [CNW-1:0] cnt_cur;
  logic [CNW-1:0] cnt_new;

  logic           held_valid_r;
  logic [LBW-1:0] held_label_r;
  logic [CNW-1:0] lost_r;
  logic           held_seen;

  logic [pts_pkg::SLOT_W-1:0] slot_r;
  logic [pts_pkg::SLOT_W-1:0] slot_lim;
  logic [pts_pkg::CFG_DATA_W-1:0] prio_shift;
  logic [LBW-1:0] walk_label;
  logic           walk_end;
  logic           walk_shoot;
  logic           walk_is_held;
  logic           walk_keep;
  logic           walk_sel;
  logic           walk_decide;
  logic           out_free;
  logic           walk_fire;

  logic           out_valid_r;
  logic           out_tgt_valid_r;
  logic [LBW-1:0] out_label_r;
  logic           out_reset_r;

  logic           sweep_rd;

  // Counter memory: one read and one write port, registered read
  logic [CNW-1:0] cnt_mem [PAIRS];

  always_ff @(posedge clk) begin
    if (sweep_rd) begin
      rd_data_r <= cnt_mem[sw_addr_r];
    end
    if (wb_vld_r) begin
      cnt_mem[wb_addr_r] <= cnt_new;
    end
  end

  // Next state
  assign sw_last = (sw_col_r == CW'(NUM_COLORS - 1)) && (sw_lab_r == LW'(NUM_LABELS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pts_pkg::ST_IDLE:  if (in_fire && in_tlast) state_nxt = pts_pkg::ST_SWEEP;
      pts_pkg::ST_SWEEP: if (sw_last) state_nxt = pts_pkg::ST_DRAIN;
      pts_pkg::ST_DRAIN: state_nxt = pts_pkg::ST_WALK;
      pts_pkg::ST_WALK:  if (walk_fire) state_nxt = pts_pkg::ST_IDLE;
      default:           state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    sweep_rd  = 1'b0;
    case (state_r)
      pts_pkg::ST_IDLE:  in_tready = 1'b1;
      pts_pkg::ST_SWEEP: sweep_rd  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Write-back value: increment when seen, saturating, else clear
  assign cnt_cur = cnt_ok_r ? rd_data_r : '0;
  always_comb begin
    if (!wb_seen_r) begin
      cnt_new = '0;
    end else if (cnt_cur == pts_pkg::CNT_MAX) begin
      cnt_new = cnt_cur;
    end else begin
      cnt_new = cnt_cur + CNW'(1);
    end
  end

  // Sweep address walk and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else begin
      wb_vld_r <= sweep_rd;
    end
    if (state_r == pts_pkg::ST_IDLE) begin
      sw_col_r  <= '0;
      sw_lab_r  <= '0;
      sw_addr_r <= '0;
    end else if (sweep_rd) begin
      sw_addr_r <= sw_addr_r + AW'(1);
      if (sw_lab_r == LW'(NUM_LABELS - 1)) begin
        sw_lab_r <= '0;
        sw_col_r <= sw_col_r + CW'(1);
      end else begin
        sw_lab_r <= sw_lab_r + LW'(1);
      end
    end
    wb_col_r  <= sw_col_r;
    wb_lab_r  <= sw_lab_r;
    wb_addr_r <= sw_addr_r;
    wb_seen_r <= seen_r[sw_col_r][sw_lab_r];
  end

  // Seen bitmap: set on detections, drop at the end of the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (state_r == pts_pkg::ST_DRAIN) begin
      seen_r <= '0;
    end else if (in_fire && det_in_range) begin
      seen_r[det_color[CW-1:0]][det_label[LW-1:0]] <= 1'b1;
    end
  end

  // Memory holds real counts once a full sweep has written every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_ok_r <= 1'b0;
    end else if (state_r == pts_pkg::ST_DRAIN) begin
      cnt_ok_r <= 1'b1;
    end
  end

  // Per-label eligibility for the target colour, captured during write-back
  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      elig_r <= '0;
      mask_r <= det_mask;
    end else if (wb_vld_r && (pts_pkg::COLOR_W'(wb_col_r) == target_color_r)) begin
      elig_r[wb_lab_r] <= (cnt_new > appear_thr_r);
    end
  end

  // Held target seen in this frame
  assign held_seen = held_valid_r && ({1'b0, target_color_r} < 4'(NUM_COLORS)) &&
                     (held_label_r < 4'(NUM_LABELS)) &&
                     seen_r[target_color_r[CW-1:0]][held_label_r[LW-1:0]];

  // Priority walk, one slot per cycle
  assign slot_lim   = (prio_count_r > pts_pkg::SLOT_W'(pts_pkg::SLOT_CAP)) ?
                      pts_pkg::SLOT_W'(pts_pkg::SLOT_CAP) : prio_count_r;
  assign prio_shift = prio_list_r >> {slot_r, 2'b00};
  assign walk_label = prio_shift[LBW-1:0];
  assign walk_end   = (slot_r >= slot_lim);
  assign walk_shoot = (walk_label < 4'(pts_pkg::SHOOT_LABELS)) &&
                      (walk_label < 4'(NUM_LABELS)) && mask_r[walk_label];
  assign walk_is_held = held_valid_r && (walk_label == held_label_r);
  assign walk_keep  = !walk_end && (walk_label != pts_pkg::EMPTY_SLOT) && walk_is_held &&
                      walk_shoot && (lost_r <= lost_limit_r);
  assign walk_sel   = !walk_end && (walk_label != pts_pkg::EMPTY_SLOT) && !walk_is_held &&
                      walk_shoot && elig_r[walk_label[LW-1:0]];
  assign walk_decide = walk_end || walk_keep || walk_sel;
  assign out_free    = !out_valid_r || out_tready;
  assign walk_fire   = (state_r == pts_pkg::ST_WALK) && walk_decide && out_free;

  always_ff @(posedge clk) begin
    if (state_r == pts_pkg::ST_DRAIN) begin
      slot_r <= '0;
    end else if ((state_r == pts_pkg::ST_WALK) && !walk_decide) begin
      slot_r <= slot_r + pts_pkg::SLOT_W'(1);
    end
  end

  // Held target and lost-frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_label_r <= '0;
      lost_r       <= '0;
    end else if (state_r == pts_pkg::ST_DRAIN) begin
      if (held_seen) begin
        lost_r <= '0;
      end else if (held_valid_r && (lost_r != pts_pkg::CNT_MAX)) begin
        lost_r <= lost_r + CNW'(1);
      end
    end else if (walk_fire && !walk_keep) begin
      if (walk_sel) begin
        held_valid_r <= 1'b1;
        held_label_r <= walk_label;
        lost_r       <= '0;
      end else begin
        held_valid_r <= 1'b0;
        held_label_r <= '0;
      end
    end
  end

  // Output register: load on decision, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (walk_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (walk_fire) begin
      out_tgt_valid_r <= walk_keep || walk_sel;
      out_label_r     <= walk_keep ? held_label_r : (walk_sel ? walk_label : '0);
      out_reset_r     <= !walk_keep;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tgt_valid_r;
  assign out_tdata  = {3'b000, out_reset_r, out_label_r};

  // Checks
  `PTS_ASSERT_NOW(a_idle_label_zero, !held_valid_r, held_label_r == '0,
    "label held without a target")
  `PTS_ASSERT_NOW(a_held_shootable, held_valid_r, held_label_r < 4'(pts_pkg::SHOOT_LABELS),
    "held label outside the shootable range")
  `PTS_ASSERT_NEXT(a_fire_loads_out, walk_fire,
    (state_r == pts_pkg::ST_IDLE) && out_tvalid, "decision did not reach the output")
  `PTS_ASSERT_NEXT(a_drain_clears, state_r == pts_pkg::ST_DRAIN,
    (state_r == pts_pkg::ST_WALK) && cnt_ok_r && (seen_r == '0),
    "sweep end did not clear the seen map")
  `PTS_ASSERT_NOW(a_keep_has_target, out_tvalid && !out_reset_r, out_tgt_valid_r,
    "kept result without a target")

endmodule

`default_nettype wire
